### sv/rtcsm_pkg.sv
// Shared types and constants for the three-wire serial clock-chip master.
package rtcsm_pkg;

  localparam int unsigned HalfPeriodW = 16;
  localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd2;
  localparam logic [2:0] LastBit = 3'd7;
  localparam logic [2:0] HighDigitBit = 3'd4;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_CE_LOW = 8'b0000_0010,
    PH_CMD_HI = 8'b0000_0100,
    PH_CMD_LO = 8'b0000_1000,
    PH_DAT_HI = 8'b0001_0000,
    PH_DAT_LO = 8'b0010_0000,
    PH_RD_HI  = 8'b0100_0000,
    PH_RD_LO  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       start_req;
    logic       opcode;
    logic [7:0] command;
    logic [7:0] write_data;
    logic       io_in;
  } req_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
  } res_t;

  typedef struct packed {
    phase_t                 phase;
    logic [2:0]             bit_count;
    logic [7:0]             shift_byte;
    logic [3:0]             low_digit;
    logic [3:0]             high_digit;
    logic [HalfPeriodW-1:0] tick_count;
    logic                   is_read;
    logic [7:0]             data_hold;
    logic [7:0]             last_value;
  } seq_state_t;

endpackage

### sv/rtcsm_step.sv
// Next-state and pin-level logic for one tick of the serial sequencer.
module rtcsm_step (
  input  rtcsm_pkg::seq_state_t                   cur,
  input  rtcsm_pkg::req_t                         req,
  input  logic [rtcsm_pkg::HalfPeriodW-1:0]       half_period,
  output rtcsm_pkg::seq_state_t                   nxt,
  output rtcsm_pkg::res_t                         res
);
  import rtcsm_pkg::*;

  logic [HalfPeriodW-1:0] hp;
  logic                   done;
  logic [2:0]             bit_inc;
  logic                   drive;

  // Shift the sampled pin into the digit selected by the bit index.
  function automatic seq_state_t enter_read_high(seq_state_t s, logic pin);
    seq_state_t r;
    r = s;
    if (s.bit_count < HighDigitBit) begin
      r.low_digit = {pin, s.low_digit[3:1]};
    end else begin
      r.high_digit = {pin, s.high_digit[3:1]};
    end
    r.phase = PH_RD_HI;
    r.tick_count = HalfPeriodW'(1);
    return r;
  endfunction

  assign hp = (half_period == '0) ? HalfPeriodW'(1) : half_period;
  assign bit_inc = cur.bit_count + 3'd1;

  always_comb begin
    nxt = cur;
    done = 1'b0;
    case (cur.phase)
      PH_IDLE: begin
        if (req.start_req) begin
          nxt.is_read = req.opcode;
          nxt.shift_byte = req.command;
          nxt.data_hold = req.write_data;
          nxt.bit_count = '0;
          nxt.low_digit = '0;
          nxt.high_digit = '0;
          nxt.tick_count = '0;
          nxt.phase = PH_CE_LOW;
        end
      end
      PH_CE_LOW: begin
        nxt.phase = PH_CMD_HI;
        nxt.tick_count = HalfPeriodW'(1);
      end
      default: begin
        if (cur.tick_count < hp) begin
          nxt.tick_count = cur.tick_count + HalfPeriodW'(1);
        end else begin
          case (cur.phase)
            PH_CMD_HI: begin
              nxt.phase = PH_CMD_LO;
              nxt.tick_count = HalfPeriodW'(1);
            end
            PH_DAT_HI: begin
              nxt.phase = PH_DAT_LO;
              nxt.tick_count = HalfPeriodW'(1);
            end
            PH_RD_HI: begin
              nxt.phase = PH_RD_LO;
              nxt.tick_count = HalfPeriodW'(1);
            end
            PH_CMD_LO, PH_DAT_LO: begin
              nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
              if (cur.bit_count == LastBit) begin
                nxt.bit_count = '0;
                if (cur.phase == PH_DAT_LO) begin
                  nxt.phase = PH_IDLE;
                  nxt.tick_count = '0;
                  done = 1'b1;
                end else if (cur.is_read) begin
                  nxt = enter_read_high(nxt, req.io_in);
                end else begin
                  nxt.shift_byte = cur.data_hold;
                  nxt.phase = PH_DAT_HI;
                  nxt.tick_count = HalfPeriodW'(1);
                end
              end else begin
                nxt.bit_count = bit_inc;
                nxt.phase = (cur.phase == PH_CMD_LO) ? PH_CMD_HI : PH_DAT_HI;
                nxt.tick_count = HalfPeriodW'(1);
              end
            end
            PH_RD_LO: begin
              if (cur.bit_count == LastBit) begin
                // high*10 + low as (high<<3) + (high<<1) + low
                nxt.last_value = {1'b0, cur.high_digit, 3'b000}
                               + {3'b000, cur.high_digit, 1'b0}
                               + {4'b0000, cur.low_digit};
                nxt.phase = PH_IDLE;
                nxt.bit_count = '0;
                nxt.tick_count = '0;
                done = 1'b1;
              end else begin
                nxt.bit_count = bit_inc;
                nxt = enter_read_high(nxt, req.io_in);
              end
            end
            default: begin
              nxt = cur;
            end
          endcase
        end
      end
    endcase
  end

  assign drive = (nxt.phase == PH_CMD_HI) || (nxt.phase == PH_CMD_LO)
              || (nxt.phase == PH_DAT_HI) || (nxt.phase == PH_DAT_LO);

  always_comb begin
    res.chip_enable = !((nxt.phase == PH_IDLE) || (nxt.phase == PH_CE_LOW));
    res.serial_clock = (nxt.phase == PH_CMD_HI) || (nxt.phase == PH_DAT_HI)
                    || (nxt.phase == PH_RD_HI);
    res.io_out = drive & nxt.shift_byte[0];
    res.io_drive = drive;
    res.busy_res = (nxt.phase != PH_IDLE);
    res.done_res = done;
    res.read_value = nxt.last_value;
  end

endmodule

### sv/three_wire_rtc_serial_master_unit.sv
// Top level of the three-wire serial clock-chip master: tick sequencer and result register.
//
// Each item on the req channel is one timing tick of the pin sequencer and
// produces exactly one item on the res channel, which carries the pin levels
// (chip enable, serial clock, data out and drive enable) after that tick, a
// busy flag, a one-tick done flag and the value of the last completed read.
// A tick with start_req set while idle latches opcode, command and write data;
// requests while busy, including the completing tick, are ignored. The
// command and then the write byte go out LSB first, each bit held for
// half_period ticks with the clock high and half_period ticks with it low; a
// read samples io_in at the start of each clock-high level and returns
// high_digit*10 + low_digit. Throughput is one item per cycle: the sequencer
// state update is a single registered pass, and the result register is
// refilled in the same cycle it is drained, so req_stall rises only while a
// result is held by res_stall. An accepted item's result is registered and
// appears in the next cycle. The half-period register (reset 2, zero acts as
// one) is written through cfg_valid/cfg_data, always ready; write it only while idle.
module three_wire_rtc_serial_master_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  rtcsm_pkg::req_t                   req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output rtcsm_pkg::res_t                   res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtcsm_pkg::HalfPeriodW-1:0] cfg_data
);
  import rtcsm_pkg::*;

  seq_state_t             state;
  seq_state_t             state_next;
  res_t                   res_next;
  logic [HalfPeriodW-1:0] half_period;
  logic                   req_take;

  // Hold new ticks only while a finished result is still waiting downstream.
  assign req_stall = res_valid & res_stall;
  assign req_take = req_valid & ~req_stall;
  assign cfg_ready = 1'b1;

  rtcsm_step u_step (
    .cur        (state),
    .req        (req),
    .half_period(half_period),
    .nxt        (state_next),
    .res        (res_next)
  );

  // Half-period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HalfPeriodReset;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  // Sequencer state: advance one tick per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_IDLE;
      state.bit_count <= '0;
      state.shift_byte <= '0;
      state.low_digit <= '0;
      state.high_digit <= '0;
      state.tick_count <= '0;
      state.is_read <= 1'b0;
      state.data_hold <= '0;
      state.last_value <= '0;
    end else if (req_take) begin
      state <= state_next;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res <= res_next;
    end
  end

endmodule
